// ----- rtl/ssm_pkg.sv -----
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types and constants of the shadow memory speculation checker.
// ----------------------------------------------------------------------------
`default_nettype none
package ssm_pkg;
	localparam int STORE_WORDS = 1024;
	localparam int WORD_AW = $clog2(STORE_WORDS);
	localparam logic [7:0] RESERVED_CODES = 8'd4;
	localparam logic [7:0] READ_LIVE_IN_CODE = 8'd1;
	localparam logic [7:0] LIVE_IN_CODE = 8'h00;

	typedef enum logic [1:0] {
		KIND_WRITE   = 2'd0,
		KIND_READ    = 2'd1,
		KIND_ADVANCE = 2'd2,
		KIND_NONE    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACCESS,
		ST_DIV
	} back_state_t;

	localparam int CFG_FIRST_ITERATION = 0;
	localparam int CFG_GRANULARITY = 1;

	typedef struct packed {
		kind_t              kind;
		logic [WORD_AW-1:0] word;
		logic [7:0]         mask;
		logic [31:0]        rel;
		logic               iter_nz;
	} item_t;

	typedef struct packed {
		logic clearing;
		logic take;
	} back_status_t;
endpackage
`default_nettype wire

// ----- rtl/shadow_memory_speculation_checker_unit.sv -----
// ----------------------------------------------------------------------------
// shadow_memory_speculation_checker_unit
// Shadow memory checker for speculative privatized accesses.
// ----------------------------------------------------------------------------
// Items enter through push/full and results leave through empty/pop; one
// result per item, in order. kind 0 writes, 1 reads, 2 advances the
// iteration code, 3 only reports the current code.
// A read or write reads the RAM, then compares and writes back. An
// advance runs the bit-serial 32-bit modulo unit. An item of kind 3 only
// loads the result register. The back end finishes each item before it
// takes the next, and takes a new item only when the result register is
// free, so a stalled pop stalls execution; the front queue holds two more
// items. After reset the 1024-word store is zeroed by a clearing pass,
// during which full stays high. Configuration writes through
// cfg_we/cfg_index/cfg_data are taken at any time but should come while
// the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none
module shadow_memory_speculation_checker_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  kind,
	input  wire logic [9:0]  word_index,
	input  wire logic [2:0]  byte_offset,
	input  wire logic [1:0]  size_code,
	input  wire logic [31:0] iteration,
	output logic             empty,
	input  wire logic        pop,
	output logic             misspeculation,
	output logic             checkpoint_due,
	output logic [7:0]       current_code,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data
);
	logic [31:0]           first_iteration_q;
	logic [7:0]            granularity_q;
	logic                  head_valid;
	ssm_pkg::item_t        head;
	ssm_pkg::back_status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_iteration_q <= 32'd0;
			granularity_q     <= 8'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				1'(ssm_pkg::CFG_FIRST_ITERATION): first_iteration_q <= cfg_data;
				1'(ssm_pkg::CFG_GRANULARITY):     granularity_q     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	ssm_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.kind            (kind),
		.word_index      (word_index),
		.byte_offset     (byte_offset),
		.size_code       (size_code),
		.iteration       (iteration),
		.first_iteration (first_iteration_q),
		.status          (status),
		.head_valid      (head_valid),
		.head            (head)
	);

	ssm_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head           (head),
		.granularity    (granularity_q),
		.status         (status),
		.empty          (empty),
		.pop            (pop),
		.misspeculation (misspeculation),
		.checkpoint_due (checkpoint_due),
		.current_code   (current_code)
	);

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		status.clearing |-> full)
		else $error("input taken during clearing pass");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(misspeculation && checkpoint_due))
		else $error("access and advance flags both set");

	a_due_code: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && checkpoint_due) |-> (current_code == ssm_pkg::RESERVED_CODES))
		else $error("checkpoint due without wrapped code");

	a_take_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		status.take |-> (head_valid && empty))
		else $error("back end took an item it had no room for");
endmodule
`default_nettype wire

// ----- rtl/ssm_ram.sv -----
// ----------------------------------------------------------------------------
// ssm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module ssm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- rtl/ssm_front.sv -----
// ----------------------------------------------------------------------------
// ssm_front
// Accepts items, decodes the byte mask and relative iteration, and queues
// them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module ssm_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output logic                      full,
	input  wire logic [1:0]           kind,
	input  wire logic [9:0]           word_index,
	input  wire logic [2:0]           byte_offset,
	input  wire logic [1:0]           size_code,
	input  wire logic [31:0]          iteration,
	input  wire logic [31:0]          first_iteration,
	input  wire ssm_pkg::back_status_t status,
	output logic                      head_valid,
	output ssm_pkg::item_t            head
);
	ssm_pkg::item_t entry_q [2];
	ssm_pkg::item_t decoded;
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           do_push;
	logic [7:0]     mask;

	always_comb begin
		case (size_code)
			2'd0:    mask = 8'h01 << byte_offset;
			2'd1:    mask = 8'h03 << {byte_offset[2:1], 1'b0};
			2'd2:    mask = 8'h0f << {byte_offset[2], 2'b00};
			default: mask = 8'hff;
		endcase
	end

	always_comb begin
		decoded.kind    = ssm_pkg::kind_t'(kind);
		decoded.word    = word_index[ssm_pkg::WORD_AW-1:0];
		decoded.mask    = mask;
		decoded.rel     = iteration - first_iteration;
		decoded.iter_nz = (iteration != 32'd0);
	end

	// hold off new items while the store is being cleared
	assign full       = (count_q == 2'd2) || status.clearing;
	assign do_push    = push && !full;
	assign head_valid = (count_q != 2'd0);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (status.take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, do_push} - {1'b0, status.take};
		end
	end
endmodule
`default_nettype wire

// ----- rtl/ssm_back.sv -----
// ----------------------------------------------------------------------------
// ssm_back
// Executes queued items: read-modify-write of the shadow store, the
// iteration code modulo, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module ssm_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 head_valid,
	input  wire ssm_pkg::item_t       head,
	input  wire logic [7:0]           granularity,
	output ssm_pkg::back_status_t     status,
	output logic                      empty,
	input  wire logic                 pop,
	output logic                      misspeculation,
	output logic                      checkpoint_due,
	output logic [7:0]                current_code
);
	ssm_pkg::back_state_t          state_q, state_next;
	ssm_pkg::item_t                item_s1;
	logic [ssm_pkg::WORD_AW-1:0]   clr_q;
	logic [4:0]                    div_cnt_q;
	logic [31:0]                   div_q;
	logic [7:0]                    rem_q;
	logic [7:0]                    code_q;
	logic                          out_valid_q;
	logic                          take;
	logic                          ram_we;
	logic [ssm_pkg::WORD_AW-1:0]   ram_waddr;
	logic [63:0]                   ram_wdata;
	logic [63:0]                   rdata;
	logic [63:0]                   new_word;
	logic                          access_mis;
	logic [7:0]                    g;
	logic [8:0]                    trial;
	logic [7:0]                    rem_next;
	logic [7:0]                    div_code;
	logic                          last_clear;
	logic                          last_div;

	ssm_ram #(.WIDTH(64), .DEPTH(ssm_pkg::STORE_WORDS)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (head.word),
		.rdata (rdata)
	);

	assign g          = (granularity == 8'd0) ? 8'd1 : granularity;
	assign trial      = {rem_q, div_q[31]};
	assign rem_next   = (trial >= {1'b0, g}) ? 8'(trial - {1'b0, g}) : trial[7:0];
	assign div_code   = rem_next + ssm_pkg::RESERVED_CODES;
	assign last_clear = (clr_q == ssm_pkg::WORD_AW'(ssm_pkg::STORE_WORDS - 1));
	assign last_div   = (div_cnt_q == 5'd0);

	always_comb begin
		logic [7:0] b;
		new_word   = rdata;
		access_mis = 1'b0;
		for (int j = 0; j < 8; j++) begin
			b = rdata[8*j +: 8];
			if (item_s1.mask[j]) begin
				if (item_s1.kind == ssm_pkg::KIND_WRITE) begin
					if (b == ssm_pkg::READ_LIVE_IN_CODE) access_mis = 1'b1;
					new_word[8*j +: 8] = code_q;
				end else if (b == ssm_pkg::LIVE_IN_CODE) begin
					new_word[8*j +: 8] = ssm_pkg::READ_LIVE_IN_CODE;
				end else if (b != code_q && b != ssm_pkg::READ_LIVE_IN_CODE) begin
					access_mis = 1'b1;
				end
			end
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ssm_pkg::ST_CLEAR: if (last_clear) state_next = ssm_pkg::ST_IDLE;
			ssm_pkg::ST_IDLE: begin
				if (take) begin
					case (head.kind)
						ssm_pkg::KIND_WRITE,
						ssm_pkg::KIND_READ:    state_next = ssm_pkg::ST_ACCESS;
						ssm_pkg::KIND_ADVANCE: state_next = ssm_pkg::ST_DIV;
						default:               state_next = ssm_pkg::ST_IDLE;
					endcase
				end
			end
			ssm_pkg::ST_ACCESS: state_next = ssm_pkg::ST_IDLE;
			ssm_pkg::ST_DIV:    if (last_div) state_next = ssm_pkg::ST_IDLE;
			default:            state_next = ssm_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		take      = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = item_s1.word;
		ram_wdata = new_word;
		case (state_q)
			ssm_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = 64'd0;
			end
			ssm_pkg::ST_IDLE:   take = head_valid && !out_valid_q;
			ssm_pkg::ST_ACCESS: ram_we = 1'b1;
			default: ;
		endcase
	end

	assign status = ssm_pkg::back_status_t'{
		clearing: (state_q == ssm_pkg::ST_CLEAR),
		take:     take
	};
	assign empty  = !out_valid_q;

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ssm_pkg::ST_CLEAR;
			clr_q          <= '0;
			div_cnt_q      <= '0;
			div_q          <= '0;
			rem_q          <= '0;
			code_q         <= ssm_pkg::RESERVED_CODES;
			out_valid_q    <= 1'b0;
			misspeculation <= 1'b0;
			checkpoint_due <= 1'b0;
			current_code   <= '0;
		end else begin
			state_q <= state_next;
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ssm_pkg::ST_CLEAR: clr_q <= clr_q + ssm_pkg::WORD_AW'(1);
				ssm_pkg::ST_IDLE: begin
					if (take) begin
						div_q     <= head.rel;
						rem_q     <= '0;
						div_cnt_q <= 5'd31;
						if (head.kind == ssm_pkg::KIND_NONE) begin
							out_valid_q    <= 1'b1;
							misspeculation <= 1'b0;
							checkpoint_due <= 1'b0;
							current_code   <= code_q;
						end
					end
				end
				ssm_pkg::ST_ACCESS: begin
					out_valid_q    <= 1'b1;
					misspeculation <= access_mis;
					checkpoint_due <= 1'b0;
					current_code   <= code_q;
				end
				ssm_pkg::ST_DIV: begin
					// one quotient bit per cycle
					rem_q     <= rem_next;
					div_q     <= {div_q[30:0], 1'b0};
					div_cnt_q <= div_cnt_q - 5'd1;
					if (last_div) begin
						code_q         <= div_code;
						out_valid_q    <= 1'b1;
						misspeculation <= 1'b0;
						checkpoint_due <= (div_code == ssm_pkg::RESERVED_CODES) &&
							item_s1.iter_nz;
						current_code   <= div_code;
					end
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire
